FILE: hdl/wav_header_parser_sample_stream_top_assert.svh
// Assertion macros used by the top module of the WAV header parser.
`ifndef WAV_HEADER_PARSER_SAMPLE_STREAM_TOP_ASSERT_SVH
`define WAV_HEADER_PARSER_SAMPLE_STREAM_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WAVHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wavhp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WAVHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wavhp: next-cycle check failed");

`endif

FILE: hdl/wavhp_pkg.sv
package wavhp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned RATE_W = 32;

  localparam logic [RATE_W-1:0] RATE_RESET = 32'd44100;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM = 16'd1;
  localparam logic [15:0] FMT_MONO = 16'd1;
  localparam logic [15:0] FMT_BITS = 16'd16;
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_ERROR  = 1'b1;

  localparam logic [CODE_W-1:0] ERR_NOT_RIFF     = 4'd0;
  localparam logic [CODE_W-1:0] ERR_NOT_WAVE     = 4'd1;
  localparam logic [CODE_W-1:0] ERR_FMT_SIZE     = 4'd2;
  localparam logic [CODE_W-1:0] ERR_NOT_PCM      = 4'd3;
  localparam logic [CODE_W-1:0] ERR_NOT_MONO     = 4'd4;
  localparam logic [CODE_W-1:0] ERR_RATE         = 4'd5;
  localparam logic [CODE_W-1:0] ERR_BITS         = 4'd6;
  localparam logic [CODE_W-1:0] ERR_FMT_MISSING  = 4'd7;
  localparam logic [CODE_W-1:0] ERR_DATA_MISSING = 4'd8;
  localparam logic [CODE_W-1:0] ERR_HEADER_SHORT = 4'd9;
  localparam logic [CODE_W-1:0] ERR_FMT_SHORT    = 4'd10;
  localparam logic [CODE_W-1:0] ERR_NONE         = 4'd0;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_word_t;

  typedef struct packed {
    logic                       result_kind;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [CODE_W-1:0]          error_code;
  } res_word_t;

endpackage

FILE: hdl/wavhp_if.sv
interface wavhp_in_if;
  import wavhp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wavhp_out_if;
  import wavhp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       result_kind;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [CODE_W-1:0]          error_code;
  modport source (output valid, output result_kind, output sample_value,
                  output error_code, input ready);
  modport sink (input valid, input result_kind, input sample_value,
                input error_code, output ready);
endinterface

interface wavhp_cfg_if;
  import wavhp_pkg::*;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] required_sample_rate;
  modport source (output valid, output required_sample_rate, input ready);
  modport sink (input valid, input required_sample_rate, output ready);
endinterface

FILE: hdl/wav_header_parser_sample_stream_top.sv
// Channel | Direction | Word
// in_ch   | sink      | data_byte[7:0], last_byte
// out_ch  | source    | result_kind, sample_value[15:0] signed, error_code[3:0]
// cfg_ch  | sink      | required_sample_rate[31:0], always ready
//
// One byte is taken per clock while in_ch.ready is high; not every byte yields a result.
// The byte passes an input register, the combinational parse logic and a result register.
// Reset is synchronous and active low; the rate register returns to 44100.
// A stalled result holds the result register and then the input register, so in_ch.ready
// falls only when both are full and out_ch.ready is low.
module wav_header_parser_sample_stream_top (
  input  logic   clk,
  input  logic   rst_n,
  wavhp_in_if.sink    in_ch,
  wavhp_out_if.source out_ch,
  wavhp_cfg_if.sink   cfg_ch
);
  import wavhp_pkg::*;

  `include "wav_header_parser_sample_stream_top_assert.svh"

  logic              stage_valid_r;
  in_word_t          stage_word_r;
  logic              out_valid_r;
  res_word_t         out_word_r;
  logic [RATE_W-1:0] rate_r;
  logic              stage_fire;
  logic              in_fire;
  logic              res_valid;
  res_word_t         res_word;

  assign stage_fire = stage_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !stage_valid_r || stage_fire;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
    end else if (cfg_ch.valid) begin
      rate_r <= cfg_ch.required_sample_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_fire) begin
      stage_valid_r <= 1'b1;
    end else if (stage_fire) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_word_r.data_byte <= in_ch.data_byte;
      stage_word_r.last_byte <= in_ch.last_byte;
    end
  end

  wavhp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_fire (stage_fire),
    .step_word (stage_word_r),
    .rate      (rate_r),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_fire) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && res_valid) begin
      out_word_r <= res_word;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.result_kind = out_word_r.result_kind;
  assign out_ch.sample_value = out_word_r.sample_value;
  assign out_ch.error_code = out_word_r.error_code;

  `WAVHP_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !stage_valid_r, in_ch.ready)
  `WAVHP_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, in_fire, stage_valid_r)
  `WAVHP_ASSERT_NOW(a_result_from_step, clk, rst_n, $rose(out_valid_r), $past(stage_fire))

endmodule

FILE: hdl/wavhp_core.sv
module wavhp_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_fire,
  input  wavhp_pkg::in_word_t             step_word,
  input  logic [wavhp_pkg::RATE_W-1:0]    rate,
  output logic                            res_valid,
  output wavhp_pkg::res_word_t            res_word
);
  import wavhp_pkg::*;

  localparam logic [2:0] PH_HDR     = 3'd0;
  localparam logic [2:0] PH_HDR_BAD = 3'd1;
  localparam logic [2:0] PH_CHUNK   = 3'd2;
  localparam logic [2:0] PH_FMT     = 3'd3;
  localparam logic [2:0] PH_SKIP    = 3'd4;
  localparam logic [2:0] PH_DATA    = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  logic [2:0]        phase_r, phase_nxt;
  logic [4:0]        pos_r, pos_nxt;
  logic [31:0]       id_r, id_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [15:0]       fcode_r, fcode_nxt;
  logic [15:0]       chans_r, chans_nxt;
  logic [31:0]       drate_r, drate_nxt;
  logic [15:0]       bits_r, bits_nxt;
  logic [31:0]       skip_r, skip_nxt;
  logic [31:0]       dleft_r, dleft_nxt;
  logic              fmt_seen_r, fmt_seen_nxt;
  logic [BYTE_W-1:0] low_r, low_nxt;
  logic              failed_r, failed_nxt;

  logic              err_valid;
  logic [CODE_W-1:0] err_code;
  logic              smp_valid;
  logic [BYTE_W-1:0] b;

  always_comb begin
    b = step_word.data_byte;
    phase_nxt = phase_r;
    pos_nxt = pos_r;
    id_nxt = id_r;
    len_nxt = len_r;
    fcode_nxt = fcode_r;
    chans_nxt = chans_r;
    drate_nxt = drate_r;
    bits_nxt = bits_r;
    skip_nxt = skip_r;
    dleft_nxt = dleft_r;
    fmt_seen_nxt = fmt_seen_r;
    low_nxt = low_r;
    failed_nxt = failed_r;
    err_valid = 1'b0;
    err_code = ERR_NONE;
    smp_valid = 1'b0;

    if (!failed_r) begin
      unique case (phase_r)
        PH_HDR, PH_HDR_BAD: begin
          id_nxt = {b, id_r[31:8]};
          if (pos_r == 5'd3 && id_nxt != ID_RIFF) begin
            phase_nxt = PH_HDR_BAD;
          end
          if (pos_r == 5'd11) begin
            if (phase_nxt == PH_HDR_BAD) begin
              err_valid = 1'b1;
              err_code = ERR_NOT_RIFF;
            end else if (id_nxt != ID_WAVE) begin
              err_valid = 1'b1;
              err_code = ERR_NOT_WAVE;
            end else begin
              phase_nxt = PH_CHUNK;
              pos_nxt = 5'd0;
            end
          end else begin
            pos_nxt = pos_r + 5'd1;
          end
        end
        PH_CHUNK: begin
          if (pos_r < 5'd4) begin
            id_nxt = {b, id_r[31:8]};
          end else begin
            len_nxt = {b, len_r[31:8]};
          end
          pos_nxt = pos_r + 5'd1;
          if (pos_nxt == 5'd8) begin
            pos_nxt = 5'd0;
            if (id_nxt == ID_FMT) begin
              fmt_seen_nxt = 1'b1;
              if (len_nxt < FMT_BODY_LEN) begin
                err_valid = 1'b1;
                err_code = ERR_FMT_SIZE;
              end else begin
                phase_nxt = PH_FMT;
              end
            end else if (id_nxt == ID_DATA) begin
              if (!fmt_seen_r) begin
                err_valid = 1'b1;
                err_code = ERR_FMT_MISSING;
              end else begin
                dleft_nxt = len_nxt;
                phase_nxt = (len_nxt < 32'd2) ? PH_DONE : PH_DATA;
              end
            end else begin
              skip_nxt = len_nxt;
              if (len_nxt != 32'd0) begin
                phase_nxt = PH_SKIP;
              end
            end
          end
        end
        PH_FMT: begin
          if (pos_r < 5'd2) begin
            fcode_nxt = {b, fcode_r[15:8]};
          end else if (pos_r < 5'd4) begin
            chans_nxt = {b, chans_r[15:8]};
          end else if (pos_r < 5'd8) begin
            drate_nxt = {b, drate_r[31:8]};
          end else if (pos_r >= 5'd14) begin
            bits_nxt = {b, bits_r[15:8]};
          end
          if (pos_r == 5'd15) begin
            pos_nxt = 5'd0;
            if (fcode_nxt != FMT_PCM) begin
              err_valid = 1'b1;
              err_code = ERR_NOT_PCM;
            end else if (chans_nxt != FMT_MONO) begin
              err_valid = 1'b1;
              err_code = ERR_NOT_MONO;
            end else if (drate_nxt != rate) begin
              err_valid = 1'b1;
              err_code = ERR_RATE;
            end else if (bits_nxt != FMT_BITS) begin
              err_valid = 1'b1;
              err_code = ERR_BITS;
            end else begin
              skip_nxt = len_r - FMT_BODY_LEN;
              phase_nxt = (skip_nxt != 32'd0) ? PH_SKIP : PH_CHUNK;
            end
          end else begin
            pos_nxt = pos_r + 5'd1;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_r - 32'd1;
          if (skip_nxt == 32'd0) begin
            phase_nxt = PH_CHUNK;
            pos_nxt = 5'd0;
          end
        end
        PH_DATA: begin
          if (pos_r == 5'd0) begin
            low_nxt = b;
            pos_nxt = 5'd1;
          end else begin
            smp_valid = 1'b1;
            pos_nxt = 5'd0;
            dleft_nxt = dleft_r - 32'd2;
            if (dleft_nxt < 32'd2) begin
              phase_nxt = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase

      if (!err_valid && step_word.last_byte) begin
        unique case (phase_nxt)
          PH_HDR, PH_HDR_BAD: begin
            err_valid = 1'b1;
            err_code = ERR_HEADER_SHORT;
          end
          PH_FMT: begin
            err_valid = 1'b1;
            err_code = ERR_FMT_SHORT;
          end
          PH_CHUNK, PH_SKIP: begin
            err_valid = 1'b1;
            err_code = fmt_seen_nxt ? ERR_DATA_MISSING : ERR_FMT_MISSING;
          end
          default: begin
          end
        endcase
      end
    end

    if (err_valid) begin
      failed_nxt = 1'b1;
    end

    if (step_word.last_byte) begin
      phase_nxt = PH_HDR;
      pos_nxt = 5'd0;
      id_nxt = 32'd0;
      len_nxt = 32'd0;
      fcode_nxt = 16'd0;
      chans_nxt = 16'd0;
      drate_nxt = 32'd0;
      bits_nxt = 16'd0;
      skip_nxt = 32'd0;
      dleft_nxt = 32'd0;
      fmt_seen_nxt = 1'b0;
      low_nxt = '0;
      failed_nxt = 1'b0;
    end
  end

  always_comb begin
    res_valid = err_valid || smp_valid;
    if (err_valid) begin
      res_word.result_kind = KIND_ERROR;
      res_word.sample_value = '0;
      res_word.error_code = err_code;
    end else begin
      res_word.result_kind = KIND_SAMPLE;
      res_word.sample_value = {b, low_r};
      res_word.error_code = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      pos_r <= 5'd0;
      id_r <= 32'd0;
      len_r <= 32'd0;
      fcode_r <= 16'd0;
      chans_r <= 16'd0;
      drate_r <= 32'd0;
      bits_r <= 16'd0;
      skip_r <= 32'd0;
      dleft_r <= 32'd0;
      fmt_seen_r <= 1'b0;
      low_r <= '0;
      failed_r <= 1'b0;
    end else if (step_fire) begin
      phase_r <= phase_nxt;
      pos_r <= pos_nxt;
      id_r <= id_nxt;
      len_r <= len_nxt;
      fcode_r <= fcode_nxt;
      chans_r <= chans_nxt;
      drate_r <= drate_nxt;
      bits_r <= bits_nxt;
      skip_r <= skip_nxt;
      dleft_r <= dleft_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      low_r <= low_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule
